### src/ttip_pkg.sv
// Shared types, character codes and helper functions of the text-to-integer parser.
package ttip_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned BASE_W      = 6;
  localparam int unsigned WORTH_W     = 7;
  localparam int unsigned NUMBER_W    = 64;
  localparam int unsigned COUNT_OUT_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 6;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_FRONT = 2'd1;

  localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;

  localparam logic [WORTH_W-1:0] WORTH_NONE = 7'd99;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LO_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FRONT,
    PH_LEAD,
    PH_ZERO,
    PH_DIGITS
  } ttip_phase_e;

  typedef struct packed {
    ttip_phase_e       phase;
    logic              minus;
    logic [BASE_W-1:0] base;
  } ttip_ctl_t;

  function automatic logic [WORTH_W-1:0] digit_worth(input logic [CHAR_W-1:0] c);
    logic [WORTH_W-1:0] w;
    w = WORTH_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      w = WORTH_W'(c - CH_ZERO);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      w = WORTH_W'(c - CH_UP_A) + 7'd10;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      w = WORTH_W'(c - CH_LO_A) + 7'd10;
    end
    return w;
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

### src/ttip_step.sv
// Per-character state update of the parser: front, prefix and digit phases in one pass.
module ttip_step import ttip_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   start_i,
  input  logic [CHAR_W-1:0]      char_i,
  input  logic [BASE_W-1:0]      radix_i,
  input  logic                   signed_front_i,
  input  ttip_ctl_t              ctl_i,
  input  logic [VALUE_WIDTH-1:0] acc_i,
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  output ttip_ctl_t              ctl_o,
  output logic [VALUE_WIDTH-1:0] acc_o,
  output logic [COUNT_WIDTH-1:0] cnt_o,
  output logic                   res_valid_o,
  output logic [NUMBER_W-1:0]    number_o,
  output logic [COUNT_OUT_W-1:0] count_o
);

  ttip_phase_e            ph;
  logic [BASE_W-1:0]      base;
  logic                   minus;
  logic [VALUE_WIDTH-1:0] acc;
  logic [COUNT_WIDTH-1:0] cnt;
  logic                   done;
  logic                   bump;
  logic                   emit;
  logic [WORTH_W-1:0]     worth;
  logic [VALUE_WIDTH-1:0] signed_val;

  assign worth = digit_worth(char_i);

  always_comb begin
    // A start flag drops whatever string was open.
    if (start_i) begin
      ph    = signed_front_i ? PH_FRONT : PH_LEAD;
      base  = radix_i;
      minus = 1'b0;
      acc   = '0;
      cnt   = '0;
    end else begin
      ph    = ctl_i.phase;
      base  = ctl_i.base;
      minus = ctl_i.minus;
      acc   = acc_i;
      cnt   = cnt_i;
    end
    done = 1'b0;
    bump = 1'b0;
    emit = 1'b0;

    // The phases fall through in order, so one character may pass several.
    if (ph == PH_FRONT) begin
      if (is_blank(char_i)) begin
        bump = 1'b1;
        done = 1'b1;
      end else if (char_i == CH_MINUS || char_i == CH_PLUS) begin
        minus = (char_i == CH_MINUS);
        bump  = 1'b1;
        done  = 1'b1;
        ph    = PH_LEAD;
      end else begin
        ph = PH_LEAD;
      end
    end
    if (!done && ph == PH_LEAD) begin
      if (base == '0 && char_i == CH_ZERO) begin
        bump = 1'b1;
        done = 1'b1;
        ph   = PH_ZERO;
      end else begin
        if (base == '0) begin
          base = BASE_DEC;
        end
        ph = PH_DIGITS;
      end
    end
    if (!done && ph == PH_ZERO) begin
      ph = PH_DIGITS;
      if (char_i == CH_LO_X || char_i == CH_UP_X) begin
        base = BASE_HEX;
        bump = 1'b1;
        done = 1'b1;
      end else begin
        base = BASE_OCT;
      end
    end
    if (!done && ph == PH_DIGITS) begin
      if (worth >= WORTH_W'(base)) begin
        emit = 1'b1;
        ph   = PH_IDLE;
      end else begin
        acc  = acc * VALUE_WIDTH'(base) + VALUE_WIDTH'(worth);
        bump = 1'b1;
      end
    end
    if (ph != PH_IDLE && ph != PH_FRONT && ph != PH_LEAD && ph != PH_ZERO &&
        ph != PH_DIGITS) begin
      ph = PH_IDLE;
    end

    if (bump && cnt != '1) begin
      cnt = cnt + 1'b1;
    end
  end

  assign signed_val  = minus ? (VALUE_WIDTH'(0) - acc) : acc;
  assign ctl_o       = '{phase: ph, minus: minus, base: base};
  assign acc_o       = acc;
  assign cnt_o       = cnt;
  assign res_valid_o = emit;
  assign number_o    = NUMBER_W'($signed(signed_val));
  assign count_o     = COUNT_OUT_W'(cnt);

endmodule

### src/text_to_integer_parser_core.sv
// Top level of the streaming text-to-integer parser with its handshake registers.
//
// Characters enter on the slave stream, one item per character: tdata carries the
// character byte and tuser the start flag that marks the first character of a string.
// Each string ends at a NUL or at the first character that is not a digit of its base;
// that character yields one result item on the master stream, holding the signed
// 64-bit value and the count of characters consumed before it. Other characters
// yield nothing.
// The configuration channel writes the radix (index 0, 0 picks the base from the
// prefix) and the signed-front flag (index 1); both are sampled when a string starts,
// and a write is held off while a character waits in the input register.
// Throughput is one character per cycle unless a stalled receiver holds the result
// register. A buffered character is processed once the result register can take a
// result: the multiply-add by the base (up to 63) updates the value and any result
// is loaded into the result register that drives m_tvalid_o. While the receiver
// stalls, the result register holds its item and the input register can still take
// one more character; the slave side stops only when both are full. Reset empties
// both registers, returns to the idle phase and loads radix 10 and signed-front 1.
module text_to_integer_parser_core import ttip_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [CHAR_W-1:0]      s_tdata_i,   // [7:0] char_code
  input  logic                   s_tuser_i,   // [0] first_char
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [79:0]            m_tdata_o,   // [63:0] number, [79:64] consumed_count
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [BASE_W-1:0]      radix_q;
  logic                   signed_front_q;

  logic                   in_valid_q;
  logic [CHAR_W-1:0]      in_char_q;
  logic                   in_first_q;

  ttip_ctl_t              ctl_q, ctl_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

  logic                   out_valid_q;
  logic [NUMBER_W-1:0]    out_number_q;
  logic [COUNT_OUT_W-1:0] out_count_q;

  logic                   res_valid;
  logic [NUMBER_W-1:0]    res_number;
  logic [COUNT_OUT_W-1:0] res_count;
  logic                   can_proc;
  logic                   proc_fire;
  logic                   in_fire;

  // A buffered character has not seen the registers yet, so writes wait for it.
  assign cfg_ready_o = !in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q        <= RADIX_RESET;
      signed_front_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RADIX:        radix_q        <= cfg_data_i;
        CFG_SIGNED_FRONT: signed_front_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The processing stage fires only when the result register can take a result.
  assign can_proc   = !out_valid_q || m_tready_i;
  assign proc_fire  = in_valid_q && can_proc;
  assign s_tready_o = !in_valid_q || can_proc;
  assign in_fire    = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_char_q  <= s_tdata_i;
      in_first_q <= s_tuser_i;
    end
  end

  ttip_step #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .start_i        (in_first_q),
    .char_i         (in_char_q),
    .radix_i        (radix_q),
    .signed_front_i (signed_front_q),
    .ctl_i          (ctl_q),
    .acc_i          (acc_q),
    .cnt_i          (cnt_q),
    .ctl_o          (ctl_d),
    .acc_o          (acc_d),
    .cnt_o          (cnt_d),
    .res_valid_o    (res_valid),
    .number_o       (res_number),
    .count_o        (res_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{phase: PH_IDLE, minus: 1'b0, base: '0};
      acc_q <= '0;
      cnt_q <= '0;
    end else if (proc_fire) begin
      ctl_q <= ctl_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && res_valid) begin
      out_number_q <= res_number;
      out_count_q  <= res_count;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_count_q, out_number_q};

  a_result_follows_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && res_valid |=> m_tvalid_o && ctl_q.phase == PH_IDLE)
    else $error("emitted result not loaded or phase not idle");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(proc_fire && res_valid))
    else $error("result appeared without a stopping character");

  a_stalled_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !can_proc |=> in_valid_q && $stable(in_char_q) && $stable(in_first_q))
    else $error("buffered character lost while stalled");

  a_state_frozen_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc_fire |=> $stable(cnt_q) && $stable(acc_q))
    else $error("parser state changed without a processed character");

endmodule

### tb/ttip_result_checker.sv
// Result checker of the text-to-integer parser: predicts every parsed value and compares.
module ttip_result_checker import ttip_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [CHAR_W-1:0]         s_tdata_i,
  input  logic                      s_tuser_i,
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [79:0]               m_tdata_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  output int                        fail_count_o,
  output int                        outstanding_o,
  output int                        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [NUMBER_W-1:0]    number;
    logic [COUNT_OUT_W-1:0] count;
  } parsed_value_t;

  parsed_value_t pending_values[$];

  int mismatches  = 0;
  int outstanding = 0;
  int checked     = 0;

  assign fail_count_o  = mismatches;
  assign outstanding_o = outstanding;
  assign checked_o     = checked;

  // Register copies and the parser state as the block should hold them.
  logic [BASE_W-1:0]      radix_q;
  logic                   sfront_q;
  ttip_phase_e            phase_q;
  logic [NUMBER_W-1:0]    acc_q;
  logic                   minus_q;
  logic [BASE_W-1:0]      base_q;
  logic [COUNT_OUT_W-1:0] count_q;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [WORTH_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return WORTH_W'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_Z) return WORTH_W'(c - CH_UP_A) + WORTH_W'(10);
    if (c >= CH_LO_A && c <= CH_LO_Z) return WORTH_W'(c - CH_LO_A) + WORTH_W'(10);
    return WORTH_NONE;
  endfunction

  function automatic logic is_space_char(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic bump_count();
    if (count_q != '1) count_q++;
  endtask

  // Advances the parser by one character; a stopping character yields a value.
  task automatic parse_char(input logic first, input logic [CHAR_W-1:0] c,
                            output logic emit, output parsed_value_t res);
    logic               done;
    logic [WORTH_W-1:0] worth;
    emit = 1'b0;
    done = 1'b0;
    res.number = '0;
    res.count  = '0;
    if (first) begin
      acc_q   = '0;
      minus_q = 1'b0;
      count_q = '0;
      base_q  = radix_q;
      phase_q = sfront_q ? PH_FRONT : PH_LEAD;
    end
    while (!done) begin
      case (phase_q)
        PH_FRONT: begin
          if (is_space_char(c)) begin
            bump_count();
            done = 1'b1;
          end else begin
            phase_q = PH_LEAD;
            if (c == CH_MINUS || c == CH_PLUS) begin
              minus_q = (c == CH_MINUS);
              bump_count();
              done = 1'b1;
            end
          end
        end
        PH_LEAD: begin
          if (base_q == '0) begin
            if (c == CH_ZERO) begin
              bump_count();
              phase_q = PH_ZERO;
              done = 1'b1;
            end else begin
              base_q = BASE_DEC;
            end
          end
          if (!done) phase_q = PH_DIGITS;
        end
        PH_ZERO: begin
          phase_q = PH_DIGITS;
          if (c == CH_LO_X || c == CH_UP_X) begin
            base_q = BASE_HEX;
            bump_count();
            done = 1'b1;
          end else begin
            base_q = BASE_OCT;
          end
        end
        PH_DIGITS: begin
          worth = char_value(c);
          if (worth >= WORTH_W'(base_q)) begin
            emit       = 1'b1;
            res.number = minus_q ? (NUMBER_W'(0) - acc_q) : acc_q;
            res.count  = count_q;
            phase_q    = PH_IDLE;
          end else begin
            acc_q = acc_q * NUMBER_W'(base_q) + NUMBER_W'(worth);
            bump_count();
          end
          done = 1'b1;
        end
        default: begin
          // A character without a start flag while idle is dropped.
          phase_q = PH_IDLE;
          done = 1'b1;
        end
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    logic          emit;
    parsed_value_t res;
    parsed_value_t want;
    if (!rst_ni) begin
      radix_q  = RADIX_RESET;
      sfront_q = 1'b1;
      phase_q  = PH_IDLE;
      acc_q    = '0;
      minus_q  = 1'b0;
      base_q   = '0;
      count_q  = '0;
      pending_values.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_RADIX) radix_q = cfg_data_i;
        else if (cfg_index_i == CFG_SIGNED_FRONT) sfront_q = cfg_data_i[0];
      end
      if (s_tvalid_i && s_tready_i) begin
        parse_char(s_tuser_i, s_tdata_i, emit, res);
        if (emit) pending_values.push_back(res);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pending_values.size() == 0) begin
          report_mismatch($sformatf("result %h/%0d with no value pending",
                                    m_tdata_i[NUMBER_W-1:0],
                                    m_tdata_i[NUMBER_W +: COUNT_OUT_W]));
        end else begin
          want = pending_values.pop_front();
          if (m_tdata_i[NUMBER_W-1:0] !== want.number) begin
            report_mismatch($sformatf("number %h, expected %h",
                                      m_tdata_i[NUMBER_W-1:0], want.number));
          end
          if (m_tdata_i[NUMBER_W +: COUNT_OUT_W] !== want.count) begin
            report_mismatch($sformatf("consumed count %0d, expected %0d",
                                      m_tdata_i[NUMBER_W +: COUNT_OUT_W], want.count));
          end
          checked++;
        end
      end
    end
    outstanding = pending_values.size();
  end

endmodule

### tb/text_to_integer_parser_core_tb.sv
// Testbench top of the text-to-integer parser: stimulus, stalls and the verdict.
module text_to_integer_parser_core_tb;
  import ttip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_CHARS  = 105;

  // Indexes that no register answers to; writes there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   s_tvalid_i  = 1'b0;
  logic                   s_tready_o;
  logic [CHAR_W-1:0]      s_tdata_i   = '0;
  logic                   s_tuser_i   = 1'b0;
  logic                   m_tvalid_o;
  logic                   m_tready_i  = 1'b0;
  logic [79:0]            m_tdata_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  int fail_count;
  int outstanding;
  int checked;

  int chars_sent    = 0;
  int settings_used = 0;
  int tx_stretch    = 0;
  bit tx_bursty     = 1'b1;
  bit steady_tail   = 1'b0;
  bit hold_off_req  = 1'b0;

  text_to_integer_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),   // [7:0] char_code
    .s_tuser_i   (s_tuser_i),   // [0] first_char
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),   // [63:0] number, [79:64] consumed_count
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  ttip_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid_i),
    .s_tready_i    (s_tready_o),
    .s_tdata_i     (s_tdata_i),
    .s_tuser_i     (s_tuser_i),
    .m_tvalid_i    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .m_tdata_i     (m_tdata_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CHAR_W-1:0] value_to_char(input int v);
    if (v < 10) return CH_ZERO + CHAR_W'(v);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + CHAR_W'(v - 10);
  endfunction

  // Any character that the given base accepts; bases past 36 take every letter.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] base);
    int top_v;
    top_v = (base > 36) ? 35 : int'(base) - 1;
    return value_to_char($urandom_range(0, top_v));
  endfunction

  function automatic logic [CHAR_W-1:0] stop_char(input logic [BASE_W-1:0] base);
    logic [CHAR_W-1:0] c;
    if (base < 36 && $urandom_range(0, 1)) return value_to_char($urandom_range(base, 35));
    do begin
      c = CHAR_W'($urandom);
    end while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               (c >= CH_LO_A && c <= CH_LO_Z));
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + CHAR_W'(r);
  endfunction

  task automatic send_char(input logic first, input logic [CHAR_W-1:0] c);
    @(negedge clk_i);
    if (!steady_tail && tx_bursty && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= first;
    s_tdata_i  <= c;
    do @(posedge clk_i); while (!s_tready_o);
    chars_sent++;
    tx_stretch--;
    if (tx_stretch <= 0) begin
      tx_stretch = $urandom_range(40, 300);
      tx_bursty  = $urandom_range(0, 1);
    end
  endtask

  task automatic send_text(input logic [CHAR_W-1:0] text[$]);
    int i;
    for (i = 0; i < text.size(); i++) send_char(i == 0, text[i]);
  endtask

  // Stops offering characters until every value is out and the block is quiet.
  task automatic settle();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input logic [BASE_W-1:0] radix, input logic sfront);
    settle();
    write_reg(CFG_RADIX, radix);
    // Upper data bits of the flag register carry junk on purpose.
    write_reg(CFG_SIGNED_FRONT, {CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)} | sfront);
    settings_used++;
  endtask

  // Mostly well-formed strings with random content; some are noise or cut short.
  task automatic send_random_string(input logic [BASE_W-1:0] radix, input logic sfront);
    logic [CHAR_W-1:0] text[$];
    logic [BASE_W-1:0] eff;
    int                kind;
    int                n;
    int                i;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) send_char(1'($urandom_range(0, 1)), CHAR_W'($urandom));
    end else begin
      eff = radix;
      if (sfront) begin
        repeat ($urandom_range(0, 2)) text.push_back(blank_char());
        case ($urandom_range(0, 2))
          0: text.push_back(CH_MINUS);
          1: text.push_back(CH_PLUS);
          default: ;
        endcase
      end
      if (radix == '0) begin
        case ($urandom_range(0, 2))
          0: begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            eff = BASE_HEX;
          end
          1: begin
            text.push_back(CH_ZERO);
            eff = BASE_OCT;
          end
          default: eff = BASE_DEC;
        endcase
      end else if ($urandom_range(0, 7) == 0) begin
        // An explicit base must not swallow a hex prefix.
        text.push_back(CH_ZERO);
        text.push_back(CH_LO_X);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 40) : $urandom_range(0, 20);
      repeat (n) text.push_back(digit_char(eff));
      if (kind != 1) text.push_back($urandom_range(0, 1) ? 8'h00 : stop_char(eff));
      send_text(text);
    end
  endtask

  task automatic run_phase(input logic [BASE_W-1:0] radix, input logic sfront);
    int mark;
    apply_setting(radix, sfront);
    mark = chars_sent;
    while (chars_sent - mark < PHASE_CHARS) send_random_string(radix, sfront);
    // Close a string that may have been left open.
    send_char(1'b0, 8'h00);
  endtask

  initial begin : result_sink
    int  rx_stretch;
    bit  rx_bursty;
    rx_stretch = 0;
    rx_bursty  = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_stretch--;
      if (rx_stretch <= 0) begin
        rx_stretch = $urandom_range(40, 300);
        rx_bursty  = $urandom_range(0, 1);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!steady_tail && rx_bursty && $urandom_range(0, 3) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL text_to_integer_parser_core");
    $finish;
  end

  initial begin : stimulus
    logic [BASE_W-1:0] radix_list[12] = '{6'd10, 6'd0, 6'd16, 6'd2, 6'd1, 6'd36,
                                          6'd63, 6'd37, 6'd8, 6'd0, 6'd10, 6'd35};
    logic              sfront_list[12] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                           1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    int                p;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: decimal with blanks and sign.
    send_text('{CH_TAB, CH_PLUS, 8'h37, 8'hFF});
    send_text('{CH_MINUS, 8'h39, 8'h00});
    send_char(1'b0, 8'h35);                 // no start flag while idle: ignored
    send_char(1'b1, 8'h31);
    send_char(1'b0, 8'h32);
    send_text('{8'h33, 8'h00});            // restart drops the open string
    send_text('{CH_PLUS, 8'h00});
    // Base taken from the prefix.
    apply_setting(6'd0, 1'b1);
    send_text('{CH_ZERO, CH_LO_X, 8'h66, 8'h46, 8'h00});
    send_text('{CH_ZERO, CH_UP_X, 8'h00});
    send_text('{CH_ZERO, 8'h37, 8'h38});

    // The sink holds off while short strings keep coming, so the block backs up.
    settle();
    hold_off_req = 1'b1;
    repeat (30) send_text('{digit_char(BASE_DEC), 8'h00});

    for (p = 0; p < 12; p++) begin
      if (p % 4 == 1) begin
        settle();
        write_reg((p % 8 == 1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_DATA_W'($urandom));
      end
      run_phase(radix_list[p], sfront_list[p]);
    end

    settle();
    steady_tail = 1'b1;
    run_phase(6'd0, 1'b1);
    settle();

    $display("Sent %0d characters across %0d register settings, including a %0d-cycle",
             chars_sent, settings_used, HOLD_CYCLES);
    $display("sink stall and full drains between settings; %0d parsed values compared.",
             checked);
    if (fail_count == 0) begin
      $display("PASS text_to_integer_parser_core");
    end else begin
      $display("FAIL text_to_integer_parser_core");
    end
    $finish;
  end

endmodule
